/* rtl/ala_pkg.sv */
// Package for the address lease allocator.
// Holds request/response/config types, register indexes and reset values.
// No dependencies.
package ala_pkg;

    localparam int MAX_LEASES_DEF = 64;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_END      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEASE_DURATION = 2'd2;

    localparam logic [31:0] RANGE_START_RST    = 32'hC0A8_0000;
    localparam logic [31:0] RANGE_END_RST      = 32'hC0A8_FFFF;
    localparam logic [30:0] LEASE_DURATION_RST = 31'd86400;

    localparam logic [7:0] LOW_BYTE_ZERO = 8'h00;
    localparam logic [7:0] LOW_BYTE_ONES = 8'hFF;

    localparam logic REQ_GRANT = 1'b0;
    localparam logic REQ_SWEEP = 1'b1;

    localparam int ENTRY_W = 96;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] node_id;
        logic        [31:0] now;
    } req_t;

    typedef struct packed {
        logic        granted;
        logic        renewed;
        logic [31:0] address;
    } rsp_t;

    typedef struct packed {
        logic [31:0] range_start;
        logic [31:0] range_end;
        logic [30:0] lease_duration;
    } cfg_t;

endpackage

/* rtl/ala_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ala_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/ala_ctrl.sv */
// Lease sequencer: walks the lease table one entry per cycle for lookup,
// sweep and address-in-use checks, and steps the scan pointer. Uses ala_pkg.
module ala_ctrl
    import ala_pkg::*;
#(
    parameter int MAX_LEASES = MAX_LEASES_DEF,
    parameter int IW         = (MAX_LEASES > 1) ? $clog2(MAX_LEASES) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  req_t               in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rsp_t               out_data,
    output logic [IW-1:0]      ram_raddr,
    input  logic [ENTRY_W-1:0] ram_rdata,
    output logic               ram_we,
    output logic [IW-1:0]      ram_waddr,
    output logic [ENTRY_W-1:0] ram_wdata
);

    typedef enum logic [2:0] {
        S_IDLE, S_WALK, S_STATIC, S_SCAN_INIT, S_SKIP, S_SCAN_TEST, S_ALLOC, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        P_SWEEP, P_LOOKUP, P_USED
    } purpose_t;

    localparam logic [IW:0] N_CNT = (IW+1)'(MAX_LEASES);

    state_t          state_reg;
    purpose_t        purpose_reg;
    logic [IW:0]     rd_cnt_reg;
    logic            pend_reg;
    logic [IW-1:0]   pend_idx_reg;
    req_t            req_reg;
    logic [MAX_LEASES-1:0] valid_reg;
    logic [31:0]     scan_ptr_reg;
    logic [32:0]     c_reg;
    logic [31:0]     cand_reg;
    logic            static_reg;
    logic            hit_reg;
    logic [IW-1:0]   slot_reg;
    logic            free_found_reg;
    logic [IW-1:0]   free_idx_reg;
    logic [31:0]     res_addr_reg;
    logic            out_valid_reg;
    rsp_t            out_data_reg;
    logic            ram_we_reg;
    logic [IW-1:0]   ram_waddr_reg;
    logic [ENTRY_W-1:0] ram_wdata_reg;

    logic [31:0] ent_node;
    logic [31:0] ent_addr;
    logic [31:0] ent_exp;
    logic [32:0] exp_sum;
    logic [31:0] new_exp;
    logic [31:0] static_cand;
    logic [32:0] c_dec;

    assign ent_node    = ram_rdata[95:64];
    assign ent_addr    = ram_rdata[63:32];
    assign ent_exp     = ram_rdata[31:0];
    assign exp_sum     = {1'b0, req_reg.now} + {2'b00, cfg.lease_duration};
    assign new_exp     = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
    assign static_cand = cfg.range_start + {req_reg.node_id[30:0], 1'b0};
    assign c_dec       = c_reg - 33'd1;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign ram_raddr = rd_cnt_reg[IW-1:0];
    assign ram_we    = ram_we_reg;
    assign ram_waddr = ram_waddr_reg;
    assign ram_wdata = ram_wdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            purpose_reg    <= P_SWEEP;
            rd_cnt_reg     <= '0;
            pend_reg       <= 1'b0;
            pend_idx_reg   <= '0;
            req_reg        <= '0;
            valid_reg      <= '0;
            scan_ptr_reg   <= '0;
            c_reg          <= '0;
            cand_reg       <= '0;
            static_reg     <= 1'b0;
            hit_reg        <= 1'b0;
            slot_reg       <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            res_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            ram_we_reg     <= 1'b0;
            ram_waddr_reg  <= '0;
            ram_wdata_reg  <= '0;
        end
        else
        begin
            ram_we_reg <= 1'b0;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg        <= in_data;
                        hit_reg        <= 1'b0;
                        free_found_reg <= 1'b0;
                        static_reg     <= 1'b0;
                        rd_cnt_reg     <= '0;
                        pend_reg       <= 1'b0;
                        purpose_reg    <= (in_data.kind == REQ_SWEEP) ? P_SWEEP : P_LOOKUP;
                        state_reg      <= S_WALK;
                    end
                end

                S_WALK:
                begin
                    if (rd_cnt_reg < N_CNT)
                    begin
                        rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    end
                    pend_reg     <= (rd_cnt_reg < N_CNT);
                    pend_idx_reg <= rd_cnt_reg[IW-1:0];

                    if (pend_reg)
                    begin
                        unique case (purpose_reg)
                            P_SWEEP:
                            begin
                                if (valid_reg[pend_idx_reg] && req_reg.now >= ent_exp)
                                begin
                                    valid_reg[pend_idx_reg] <= 1'b0;
                                end
                            end
                            P_LOOKUP:
                            begin
                                if (valid_reg[pend_idx_reg] && ent_node == req_reg.node_id)
                                begin
                                    hit_reg      <= 1'b1;
                                    slot_reg     <= pend_idx_reg;
                                    res_addr_reg <= ent_addr;
                                    pend_reg     <= 1'b0;
                                    state_reg    <= S_ALLOC;
                                end
                                else if (!valid_reg[pend_idx_reg] && !free_found_reg)
                                begin
                                    free_found_reg <= 1'b1;
                                    free_idx_reg   <= pend_idx_reg;
                                end
                            end
                            P_USED:
                            begin
                                if (valid_reg[pend_idx_reg] && ent_addr == cand_reg)
                                begin
                                    pend_reg <= 1'b0;
                                    if (static_reg)
                                    begin
                                        state_reg <= S_SCAN_INIT;
                                    end
                                    else
                                    begin
                                        c_reg     <= c_dec;
                                        state_reg <= S_SKIP;
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    else if (rd_cnt_reg == N_CNT)
                    begin
                        unique case (purpose_reg)
                            P_SWEEP:  state_reg <= S_IDLE;
                            P_LOOKUP: state_reg <= S_STATIC;
                            P_USED:
                            begin
                                res_addr_reg <= cand_reg;
                                if (!static_reg)
                                begin
                                    scan_ptr_reg <= cand_reg;
                                end
                                state_reg <= S_ALLOC;
                            end
                            default:  state_reg <= S_IDLE;
                        endcase
                    end
                end

                S_STATIC:
                begin
                    if (!req_reg.node_id[31] && req_reg.node_id != 32'sd0 &&
                        static_cand >= cfg.range_start && static_cand <= cfg.range_end)
                    begin
                        cand_reg    <= static_cand;
                        static_reg  <= 1'b1;
                        purpose_reg <= P_USED;
                        rd_cnt_reg  <= '0;
                        pend_reg    <= 1'b0;
                        state_reg   <= S_WALK;
                    end
                    else
                    begin
                        state_reg <= S_SCAN_INIT;
                    end
                end

                S_SCAN_INIT:
                begin
                    static_reg <= 1'b0;
                    if (scan_ptr_reg < cfg.range_start || scan_ptr_reg > cfg.range_end)
                    begin
                        c_reg     <= {1'b0, cfg.range_end};
                        state_reg <= S_SKIP;
                    end
                    else
                    begin
                        c_reg     <= {1'b0, scan_ptr_reg};
                        state_reg <= S_SCAN_TEST;
                    end
                end

                S_SKIP:
                begin
                    if (!c_reg[32] &&
                        (c_reg[7:0] == LOW_BYTE_ZERO || c_reg[7:0] == LOW_BYTE_ONES))
                    begin
                        c_reg <= c_dec;
                    end
                    else
                    begin
                        state_reg <= S_SCAN_TEST;
                    end
                end

                S_SCAN_TEST:
                begin
                    if (!c_reg[32] && c_reg[31:0] >= cfg.range_start)
                    begin
                        cand_reg    <= c_reg[31:0];
                        purpose_reg <= P_USED;
                        rd_cnt_reg  <= '0;
                        pend_reg    <= 1'b0;
                        state_reg   <= S_WALK;
                    end
                    else
                    begin
                        scan_ptr_reg <= c_reg[31:0];
                        res_addr_reg <= '0;
                        hit_reg      <= 1'b0;
                        free_found_reg <= 1'b0;
                        state_reg    <= S_ALLOC;
                    end
                end

                S_ALLOC:
                begin
                    // hit: renew; free slot: new lease; else deny
                    if (hit_reg)
                    begin
                        ram_we_reg    <= 1'b1;
                        ram_waddr_reg <= slot_reg;
                        ram_wdata_reg <= {req_reg.node_id, res_addr_reg, new_exp};
                    end
                    else if (free_found_reg)
                    begin
                        valid_reg[free_idx_reg] <= 1'b1;
                        ram_we_reg    <= 1'b1;
                        ram_waddr_reg <= free_idx_reg;
                        ram_wdata_reg <= {req_reg.node_id, res_addr_reg, new_exp};
                    end
                    else
                    begin
                        res_addr_reg <= '0;
                    end
                    state_reg <= S_DONE;
                end

                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg        <= 1'b1;
                        out_data_reg.granted <= hit_reg || free_found_reg;
                        out_data_reg.renewed <= hit_reg;
                        out_data_reg.address <= res_addr_reg;
                        state_reg            <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/address_lease_allocator.sv */
// Top level of the address lease allocator: config registers, lease RAM and
// sequencer. Uses ala_pkg, ala_ram, ala_ctrl.
//
//  channel | signals                       | direction
//  in      | in_valid/in_ready/in_data     | request in (grant or sweep)
//  out     | out_valid/out_ready/out_data  | grant response out
//  cfg     | cfg_we/cfg_index/cfg_wdata    | register write, no wait
//
// Sweep: one table walk. Grant: one table walk for lookup, plus one walk per
// address tested (static try and each scan step), plus pointer stepping;
// bounded by the single table read port.
// Reset is asynchronous; all lease valid bits clear at once, no clearing pass.
// in_ready is low from accept until the response is loaded into the output
// register or a sweep's walk ends; a stalled output holds the block in S_DONE.
module address_lease_allocator
    import ala_pkg::*;
#(
    parameter int MAX_LEASES = MAX_LEASES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  req_t                 in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rsp_t                 out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_wdata
);

    localparam int IW = (MAX_LEASES > 1) ? $clog2(MAX_LEASES) : 1;

    cfg_t cfg_reg;

    logic [IW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_start    <= RANGE_START_RST;
            cfg_reg.range_end      <= RANGE_END_RST;
            cfg_reg.lease_duration <= LEASE_DURATION_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RANGE_START:    cfg_reg.range_start    <= cfg_wdata;
                CFG_RANGE_END:      cfg_reg.range_end      <= cfg_wdata;
                CFG_LEASE_DURATION: cfg_reg.lease_duration <= cfg_wdata[30:0];
                default:
                begin
                end
            endcase
        end
    end

    ala_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_LEASES),
        .AW    (IW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ala_ctrl #(
        .MAX_LEASES (MAX_LEASES),
        .IW         (IW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

endmodule

/* rtl/ala_checker.sv */
// Port-level checks for address_lease_allocator, bound to the top level.
// Uses ala_pkg.
module ala_checker
    import ala_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input rsp_t                 out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("response changed while stalled");

    a_deny_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.granted |-> out_data.address == 32'd0 && !out_data.renewed)
        else $error("denied response not cleared");

    a_renew_grant: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.renewed |-> out_data.granted)
        else $error("renewed without grant");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after request");

endmodule

bind address_lease_allocator ala_checker u_ala_checker (.*);

/* sim/tb_address_lease_allocator.sv */
// Testbench for address_lease_allocator: directed and random grant/sweep requests,
// checked against a lease-table scoreboard. Depends on rtl/ala_pkg.sv and the
// top-level RTL.
`timescale 1ns / 100ps

module tb_address_lease_allocator;
    import ala_pkg::*;

    localparam int TABLE_SIZE  = 64;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int IDLE_WAIT   = 200;
    localparam int LONG_HOLD   = 3000;

    class lease_scoreboard;
        logic [31:0] pool_lo;
        logic [31:0] pool_hi;
        logic [30:0] duration;
        bit          held[TABLE_SIZE];
        logic [31:0] holder[TABLE_SIZE];
        logic [31:0] addr_of[TABLE_SIZE];
        logic [31:0] expires[TABLE_SIZE];
        logic [31:0] scan_ptr;
        rsp_t        grants_due[$];
        int          errors;

        function new();
            pool_lo  = RANGE_START_RST;
            pool_hi  = RANGE_END_RST;
            duration = LEASE_DURATION_RST;
            scan_ptr = '0;
            errors   = 0;
            foreach (held[i])
            begin
                held[i] = 1'b0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                CFG_RANGE_START:    pool_lo  = val;
                CFG_RANGE_END:      pool_hi  = val;
                CFG_LEASE_DURATION: duration = val[30:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] expiry_from(logic [31:0] now);
            longint s;
            s = longint'({32'b0, now}) + longint'({33'b0, duration});
            return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function bit addr_taken(logic [31:0] a);
            foreach (held[i])
            begin
                if (held[i] && addr_of[i] == a)
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function longint skip_low_byte(longint c);
            logic [7:0] lb;
            while (c >= 0)
            begin
                lb = c[7:0];
                if (lb != LOW_BYTE_ZERO && lb != LOW_BYTE_ONES)
                    break;
                c--;
            end
            return c;
        endfunction

        function bit find_free(logic [31:0] id, output logic [31:0] a);
            logic [31:0] cand;
            longint      c;
            longint      lo;
            bit          hit;
            cand = pool_lo + {id[30:0], 1'b0};
            hit  = 1'b0;
            a    = '0;
            if (!id[31] && id != 0 && cand >= pool_lo && cand <= pool_hi
                && !addr_taken(cand))
            begin
                a = cand;
                return 1'b1;
            end
            lo = longint'({32'b0, pool_lo});
            c  = longint'({32'b0, scan_ptr});
            if (scan_ptr < pool_lo || scan_ptr > pool_hi)
                c = skip_low_byte(longint'({32'b0, pool_hi}));
            while (c >= 0 && c >= lo)
            begin
                if (!addr_taken(c[31:0]))
                begin
                    a   = c[31:0];
                    hit = 1'b1;
                    break;
                end
                c = skip_low_byte(c - 1);
            end
            scan_ptr = c[31:0];
            return hit;
        endfunction

        function void note_request(req_t r);
            logic [31:0] id;
            logic [31:0] a;
            rsp_t        g;
            int          slot;
            id   = r.node_id;
            g    = '0;
            slot = -1;
            if (r.kind == REQ_SWEEP)
            begin
                foreach (held[i])
                begin
                    if (held[i] && r.now >= expires[i])
                        held[i] = 1'b0;
                end
                return;
            end
            foreach (held[i])
            begin
                if (held[i] && holder[i] == id)
                begin
                    expires[i] = expiry_from(r.now);
                    g.granted  = 1'b1;
                    g.renewed  = 1'b1;
                    g.address  = addr_of[i];
                    grants_due.push_back(g);
                    return;
                end
            end
            if (find_free(id, a))
            begin
                foreach (held[i])
                begin
                    if (!held[i] && slot < 0)
                        slot = i;
                end
                if (slot >= 0)
                begin
                    held[slot]    = 1'b1;
                    holder[slot]  = id;
                    addr_of[slot] = a;
                    expires[slot] = expiry_from(r.now);
                    g.granted     = 1'b1;
                    g.address     = a;
                end
            end
            grants_due.push_back(g);
        endfunction

        function void check_grant(rsp_t got);
            rsp_t want;
            if (grants_due.size() == 0)
            begin
                $error("unexpected response %p", got);
                errors++;
                return;
            end
            want = grants_due.pop_front();
            if (got.granted !== want.granted)
            begin
                $error("granted: expected %0b actual %0b", want.granted, got.granted);
                errors++;
            end
            if (got.renewed !== want.renewed)
            begin
                $error("renewed: expected %0b actual %0b", want.renewed, got.renewed);
                errors++;
            end
            if (got.address !== want.address)
            begin
                $error("address: expected %h actual %h", want.address, got.address);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    req_t                 in_data;
    logic                 out_valid;
    logic                 out_ready;
    rsp_t                 out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_wdata;

    lease_scoreboard leases = new();
    int              cycles = 0;
    bit              long_hold = 1'b0;
    bit              eager = 1'b0;
    logic [31:0]     clock_now = 32'd1000;

    address_lease_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            leases.check_grant(out_data);
    end

    // response side: random stalls, one long hold on request
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = eager ? 0 : $urandom_range(0, 12);
            if (long_hold)
            begin
                stall     = LONG_HOLD;
                long_hold = 1'b0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    task automatic send(bit kind, logic [31:0] id, logic [31:0] now);
        req_t r;
        int   gap;
        r.kind    = kind;
        r.node_id = id;
        r.now     = now;
        gap = eager ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= r;
        do
            @(posedge clk);
        while (!in_ready);
        leases.note_request(r);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (leases.grants_due.size() != 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        leases.write_reg(idx, val);
    endtask

    task automatic set_pool(logic [31:0] lo, logic [31:0] hi, logic [31:0] dur);
        drain();
        write_reg(CFG_RANGE_START, lo);
        write_reg(CFG_RANGE_END, hi);
        write_reg(CFG_LEASE_DURATION, dur);
    endtask

    task automatic random_requests(int n, int id_span);
        logic [31:0] id;
        int          pick;
        for (int i = 0; i < n; i++)
        begin
            if (i % 20 == 0)
                eager = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 70)
                id = $urandom_range(1, id_span);
            else if (pick < 80)
                id = -$urandom_range(0, 3);
            else
                id = $urandom;
            if ($urandom_range(0, 9) == 0)
                clock_now = $urandom;
            else
                clock_now = clock_now + $urandom_range(0, 20000);
            send($urandom_range(0, 99) < 15, id, clock_now);
        end
        eager = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_RANGE_START;
        cfg_wdata = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset pool: static, renew, scan, id edge cases, time edge cases
        send(REQ_GRANT, 32'd1, 32'd0);
        send(REQ_GRANT, 32'd1, 32'hFFFF_FFF0);
        send(REQ_GRANT, 32'd0, 32'd5);
        send(REQ_GRANT, 32'hFFFF_FFFF, 32'd5);
        send(REQ_GRANT, 32'h8000_0000, 32'hFFFF_FFFF);
        send(REQ_GRANT, 32'h7FFF_FFFF, 32'd7);
        send(REQ_GRANT, 32'd32767, 32'd8);
        send(REQ_GRANT, 32'd32768, 32'd9);
        send(REQ_GRANT, 32'd32768, 32'd10);
        send(REQ_SWEEP, 32'hFFFF_FFFF, 32'd86409);
        send(REQ_GRANT, 32'd2, 32'd11);
        send(REQ_SWEEP, 32'd0, 32'hFFFF_FFFF);

        // tiny pool straddling a 00/FF boundary, zero duration
        set_pool(32'h0000_01FE, 32'h0000_0201, 32'd0);
        for (int i = 0; i < 5; i++)
            send(REQ_GRANT, 32'd100 + i, 32'd50);
        send(REQ_SWEEP, 32'd0, 32'd50);
        send(REQ_GRANT, 32'd1, 32'd60);

        set_pool(32'd0, 32'd0, 32'hFFFF_FFFF);
        send(REQ_GRANT, 32'd1, 32'd1);
        send(REQ_GRANT, 32'd0, 32'hFFFF_FFFF);
        set_pool(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
        send(REQ_GRANT, 32'd3, 32'd1);
        set_pool(32'h0000_0010, 32'h0000_0005, 32'd10);
        send(REQ_GRANT, 32'd4, 32'd1);
        send(REQ_SWEEP, 32'd0, 32'hFFFF_FFFF);

        // whole space, maximum duration: table fills, then long output hold
        set_pool(32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        for (int i = 0; i < 66; i++)
            send(REQ_GRANT, 32'd200 + i, 32'd0);
        long_hold = 1'b1;
        random_requests(20, 90);
        send(REQ_SWEEP, 32'd0, 32'hFFFF_FFFF);

        set_pool(RANGE_START_RST, RANGE_END_RST, LEASE_DURATION_RST);
        random_requests(15, 90);
        set_pool(32'hC0A8_00FC, 32'hC0A8_0106, 32'd50000);
        random_requests(15, 12);

        drain();
        if (leases.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
